FILE: rtl/sobel_pkg.sv
// ----------------------------------------------------------------------------
// sobel_pkg
// Shared types and constants for the Sobel L1 edge magnitude block.
// ----------------------------------------------------------------------------
package sobel_pkg;

    localparam int MAX_LINE_WIDTH = 2048;
    localparam int MIN_LINE_WIDTH = 4;
    localparam int COL_W          = $clog2(MAX_LINE_WIDTH);
    localparam int WIDTH_W        = 12;
    localparam int GAIN_W         = 16;
    localparam int GREY_W         = 10;
    localparam int GRAD_W         = 13;
    localparam int L1_W           = 13;
    localparam int LEVEL_W        = 8;
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 16;

    localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_GAIN       = CFG_IDX_W'(1);

    localparam logic [WIDTH_W-1:0] LINE_WIDTH_RST = WIDTH_W'(640);
    localparam logic [GAIN_W-1:0]  GAIN_RST       = GAIN_W'(26214);

    typedef struct packed {
        logic [31:0] pixel;
        logic        frame_start;
    } t_in;

    typedef struct packed {
        logic [LEVEL_W-1:0] edge_level;
        logic               first_result;
    } t_out;

    // Per-pixel position info produced at acceptance
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic             produce;
        logic             first;
    } t_pos;

endpackage

FILE: rtl/sobel_ram.sv
// ----------------------------------------------------------------------------
// sobel_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module sobel_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/sobel_ctrl.sv
// ----------------------------------------------------------------------------
// sobel_ctrl
// Column/row tracking, width clamp and result qualification per pixel.
// ----------------------------------------------------------------------------
module sobel_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_acc,
    input  logic                            i_frame_start,
    input  logic [sobel_pkg::WIDTH_W-1:0]   i_line_width,
    output sobel_pkg::t_pos                 o_pos
);

    logic [sobel_pkg::COL_W-1:0]   r_col, n_col;
    logic [1:0]                    r_row, n_row;
    logic                          r_first, n_first;
    logic [sobel_pkg::COL_W-1:0]   col;
    logic [1:0]                    row;
    logic                          first;
    logic                          produce;
    logic                          wrap;
    logic [sobel_pkg::WIDTH_W-1:0] width;
    logic [sobel_pkg::WIDTH_W-1:0] col_inc;

    always_comb begin
        if (i_line_width < sobel_pkg::WIDTH_W'(sobel_pkg::MIN_LINE_WIDTH)) begin
            width = sobel_pkg::WIDTH_W'(sobel_pkg::MIN_LINE_WIDTH);
        end else if (i_line_width > sobel_pkg::WIDTH_W'(sobel_pkg::MAX_LINE_WIDTH)) begin
            width = sobel_pkg::WIDTH_W'(sobel_pkg::MAX_LINE_WIDTH);
        end else begin
            width = i_line_width;
        end

        col     = i_frame_start ? '0   : r_col;
        row     = i_frame_start ? '0   : r_row;
        first   = i_frame_start ? 1'b1 : r_first;
        produce = (row == 2'd2) && (col >= sobel_pkg::COL_W'(2));
        col_inc = sobel_pkg::WIDTH_W'(col) + sobel_pkg::WIDTH_W'(1);
        wrap    = col_inc >= width;

        n_col   = wrap ? '0 : col_inc[sobel_pkg::COL_W-1:0];
        n_row   = (wrap && row != 2'd2) ? row + 2'd1 : row;
        n_first = produce ? 1'b0 : first;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col   <= '0;
            r_row   <= '0;
            r_first <= 1'b1;
        end else if (i_acc) begin
            r_col   <= n_col;
            r_row   <= n_row;
            r_first <= n_first;
        end
    end

    assign o_pos.col     = col;
    assign o_pos.produce = produce;
    assign o_pos.first   = first;

endmodule

FILE: rtl/sobel_grad.sv
// ----------------------------------------------------------------------------
// sobel_grad
// 3x3 window shift register and Sobel X/Y gradients summed as L1 norm.
// ----------------------------------------------------------------------------
module sobel_grad (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_shift,
    input  logic [sobel_pkg::GREY_W-1:0]   i_top,
    input  logic [sobel_pkg::GREY_W-1:0]   i_mid,
    input  logic [sobel_pkg::GREY_W-1:0]   i_bot,
    output logic [sobel_pkg::L1_W-1:0]     o_l1
);

    // r_win[0..2]: column c-2 (top, mid, bottom); r_win[3..5]: column c-1
    logic [sobel_pkg::GREY_W-1:0]        r_win [6];
    logic signed [sobel_pkg::GRAD_W-1:0] a1, a2, a3, a4, a6, a7, a8, a9;
    logic signed [sobel_pkg::GRAD_W-1:0] gx, gy;
    logic [sobel_pkg::GRAD_W-1:0]        abs_x, abs_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (i_shift) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= i_top;
            r_win[4] <= i_mid;
            r_win[5] <= i_bot;
        end
    end

    always_comb begin
        a1 = signed'(sobel_pkg::GRAD_W'(r_win[0]));
        a4 = signed'(sobel_pkg::GRAD_W'(r_win[1]));
        a7 = signed'(sobel_pkg::GRAD_W'(r_win[2]));
        a2 = signed'(sobel_pkg::GRAD_W'(r_win[3]));
        a8 = signed'(sobel_pkg::GRAD_W'(r_win[5]));
        a3 = signed'(sobel_pkg::GRAD_W'(i_top));
        a6 = signed'(sobel_pkg::GRAD_W'(i_mid));
        a9 = signed'(sobel_pkg::GRAD_W'(i_bot));
        gx = (a3 - a1) + ((a6 - a4) <<< 1) + (a9 - a7);
        gy = (a7 - a1) + ((a8 - a2) <<< 1) + (a9 - a3);
        abs_x = gx[sobel_pkg::GRAD_W-1] ? sobel_pkg::GRAD_W'(-gx) : sobel_pkg::GRAD_W'(gx);
        abs_y = gy[sobel_pkg::GRAD_W-1] ? sobel_pkg::GRAD_W'(-gy) : sobel_pkg::GRAD_W'(gy);
        o_l1  = sobel_pkg::L1_W'(abs_x + abs_y);
    end

endmodule

FILE: rtl/sobel_scale.sv
// ----------------------------------------------------------------------------
// sobel_scale
// Q0.16 gain multiply, truncation and saturation to 8 bits.
// ----------------------------------------------------------------------------
module sobel_scale (
    input  logic [sobel_pkg::L1_W-1:0]    i_l1,
    input  logic [sobel_pkg::GAIN_W-1:0]  i_gain,
    output logic [sobel_pkg::LEVEL_W-1:0] o_level
);

    localparam int PROD_W = sobel_pkg::L1_W + sobel_pkg::GAIN_W;

    logic [PROD_W-1:0]            prod;
    logic [sobel_pkg::L1_W-1:0]   scaled;

    always_comb begin
        prod   = PROD_W'(i_l1) * PROD_W'(i_gain);
        scaled = prod[PROD_W-1:sobel_pkg::GAIN_W];
        if (scaled > sobel_pkg::L1_W'(255)) begin
            o_level = '1;
        end else begin
            o_level = scaled[sobel_pkg::LEVEL_W-1:0];
        end
    end

endmodule

FILE: rtl/sobel_edge_magnitude_l1.sv
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_l1
// Streaming 3x3 Sobel edge magnitude (L1 norm) with gain and saturation.
// ----------------------------------------------------------------------------
// Accepts one pixel per clock while the output is not stalled and delivers at
// most one result per pixel, registered in stage 1, stage 2 and the result
// register, for the interior pixel one row up and one column left. Border
// pixels produce no result. Throughput is set by the line store, a 2048 x 20
// RAM with one write and one registered read per cycle; a pixel that re-reads
// the column written by the previous pixel is served by forwarding. Stalls on
// the output hold the whole pipeline. Configuration writes are always accepted
// (index 0: line width, index 1: gain).
module sobel_edge_magnitude_l1 (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  sobel_pkg::t_in                     i_data,
    output logic                               o_valid,
    input  logic                               i_ready,
    output sobel_pkg::t_out                    o_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [sobel_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sobel_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int LS_W = 2 * sobel_pkg::GREY_W;

    logic [sobel_pkg::WIDTH_W-1:0] r_line_width;
    logic [sobel_pkg::GAIN_W-1:0]  r_gain;

    logic                          en;
    logic                          in_acc;
    logic                          s1_go;
    sobel_pkg::t_pos               pos;
    logic [sobel_pkg::GREY_W-1:0]  grey;

    logic                          r_v1;
    sobel_pkg::t_pos               r_pos1;
    logic [sobel_pkg::GREY_W-1:0]  r_g1;
    logic                          r_fwd1;
    logic [LS_W-1:0]               r_fwd_data1;
    logic [LS_W-1:0]               ls_rdata;
    logic [sobel_pkg::GREY_W-1:0]  top1, mid1;
    logic [sobel_pkg::L1_W-1:0]    l1;

    logic                          r_v2;
    logic                          r_first2;
    logic [sobel_pkg::L1_W-1:0]    r_l12;
    logic [sobel_pkg::LEVEL_W-1:0] level;

    logic                          r_out_valid;
    sobel_pkg::t_out               r_out;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width <= sobel_pkg::LINE_WIDTH_RST;
            r_gain       <= sobel_pkg::GAIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sobel_pkg::REG_LINE_WIDTH: begin
                    r_line_width <= i_cfg_data[sobel_pkg::WIDTH_W-1:0];
                end
                sobel_pkg::REG_GAIN: begin
                    r_gain <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    // pipeline control
    assign en      = !r_out_valid || i_ready;
    assign in_acc  = i_valid && en;
    assign s1_go   = r_v1 && en;
    assign o_ready = en;

    sobel_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_acc         (in_acc),
        .i_frame_start (i_data.frame_start),
        .i_line_width  (r_line_width),
        .o_pos         (pos)
    );

    assign grey = sobel_pkg::GREY_W'(i_data.pixel[7:0])
                + sobel_pkg::GREY_W'(i_data.pixel[15:8])
                + sobel_pkg::GREY_W'(i_data.pixel[23:16]);

    // line store: {top row, middle row}
    sobel_ram #(
        .WIDTH (LS_W),
        .DEPTH (sobel_pkg::MAX_LINE_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (s1_go),
        .i_waddr (r_pos1.col),
        .i_wdata ({mid1, r_g1}),
        .i_re    (in_acc),
        .i_raddr (pos.col),
        .o_rdata (ls_rdata)
    );

    // stage 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pos1      <= pos;
            r_g1        <= grey;
            r_fwd1      <= s1_go && (r_pos1.col == pos.col);
            r_fwd_data1 <= {mid1, r_g1};
        end
    end

    assign top1 = r_fwd1 ? r_fwd_data1[LS_W-1:sobel_pkg::GREY_W]
                         : ls_rdata[LS_W-1:sobel_pkg::GREY_W];
    assign mid1 = r_fwd1 ? r_fwd_data1[sobel_pkg::GREY_W-1:0]
                         : ls_rdata[sobel_pkg::GREY_W-1:0];

    sobel_grad u_grad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_shift (s1_go),
        .i_top   (top1),
        .i_mid   (mid1),
        .i_bot   (r_g1),
        .o_l1    (l1)
    );

    // stage 2
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v2 <= r_v1 && r_pos1.produce;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_l12    <= l1;
            r_first2 <= r_pos1.first;
        end
    end

    sobel_scale u_scale (
        .i_l1    (r_l12),
        .i_gain  (r_gain),
        .o_level (level)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_v2) begin
            r_out.edge_level   <= level;
            r_out.first_result <= r_first2;
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
